// ===== hw/rtl/lpm_pkg.sv =====
// lpm_pkg: shared types, codes and constants of the longest prefix match lookup unit
// no dependencies; used by longest_prefix_match_lookup_unit, lpm_match_unit and the bench
`timescale 1ns / 1ps
`default_nettype none

package lpm_pkg;

	localparam int ADDR_W      = 32;
	localparam int LEN_W       = 6;
	localparam int PORT_W      = 8;
	localparam int FUNC_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 56;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_BAD_LEN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic entry_vld;
	} scan_ctl_t;

	typedef struct packed {
		logic              found;
		logic [PORT_W-1:0] port;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] net;
	} match_res_t;

	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		prefix_mask = ~({ADDR_W{1'b1}} >> len);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/longest_prefix_match_lookup_unit.sv =====
// longest_prefix_match_lookup_unit: ipv4 route table with add, lookup and clear
// depends on lpm_pkg, lpm_route_ram and lpm_match_unit
//
// channel  dir  signals                  beat contents
// s_axis   in   tvalid tready tdata tuser one command: add, lookup or clear
// m_axis   out  tvalid tready tdata       one result per command
//
// lookup: the scan in ST_SCAN reads the route ram one entry a cycle through the shared
//   compare unit, then ST_DONE loads the result; on an empty table the scan ends at once
// add, clear: ST_EXEC writes the route or clears the count, then ST_DONE loads the result
// reset clears the route count but not the ram; ram contents are never read before written
// a finished result waits in the output register; a new command is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_match_lookup_unit #(
	parameter int TABLE_DEPTH = 128,
	parameter int PORT_BITS   = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// route_network, route_length, route_port, destination, zero pad
	input  wire logic [lpm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// func
	input  wire logic [lpm_pkg::FUNC_W-1:0]       s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// status, matched, best_port, best_length, best_network, zero pad
	output logic      [lpm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int PW     = (PORT_BITS < lpm_pkg::PORT_W) ? PORT_BITS : lpm_pkg::PORT_W;
	localparam int DATA_W = lpm_pkg::ADDR_W + lpm_pkg::LEN_W + PW;
	localparam logic [lpm_pkg::PORT_W-1:0] PORT_MAX = lpm_pkg::PORT_W'((1 << PW) - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	lpm_pkg::state_t state_q, state_d;

	logic [lpm_pkg::FUNC_W-1:0]   func_q;
	logic [lpm_pkg::ADDR_W-1:0]   rnet_q;
	logic [lpm_pkg::LEN_W-1:0]    rlen_q;
	logic [lpm_pkg::PORT_W-1:0]   rport_q;
	logic [lpm_pkg::ADDR_W-1:0]   dest_q;
	lpm_pkg::status_t             status_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             idx_q;
	logic                         rd_vld_s1;
	logic                         m_valid_q;
	logic [lpm_pkg::OUT_TDATA_W-1:0] m_data_q;

	logic                         accept;
	logic                         out_free;
	logic                         scan_rd;
	logic                         mem_we;
	logic                         out_load;
	logic [lpm_pkg::PORT_W-1:0]   port_sat;
	logic [DATA_W-1:0]            wr_data;
	logic [DATA_W-1:0]            rd_data;
	lpm_pkg::scan_ctl_t           scan_ctl;
	lpm_pkg::match_res_t          match_res;
	logic [lpm_pkg::OUT_TDATA_W-1:0] result;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpm_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (s_axis_tuser == lpm_pkg::FUNC_LOOKUP) ?
						lpm_pkg::ST_SCAN : lpm_pkg::ST_EXEC;
				end
			end
			lpm_pkg::ST_EXEC: begin
				state_d = lpm_pkg::ST_DONE;
			end
			lpm_pkg::ST_SCAN: begin
				if ((idx_q == count_q) && !rd_vld_s1) begin
					state_d = lpm_pkg::ST_DONE;
				end
			end
			lpm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = lpm_pkg::ST_IDLE;
				end
			end
			default: state_d = lpm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready      = (state_q == lpm_pkg::ST_IDLE);
		scan_rd            = (state_q == lpm_pkg::ST_SCAN) && (idx_q != count_q);
		mem_we             = (state_q == lpm_pkg::ST_EXEC) && (func_q == lpm_pkg::FUNC_ADD)
			&& (rlen_q <= lpm_pkg::MAX_LEN) && (count_q < DEPTH_CNT);
		out_load           = (state_q == lpm_pkg::ST_DONE) && out_free;
		scan_ctl.start     = accept;
		scan_ctl.entry_vld = rd_vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command fields
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= s_axis_tuser;
			rnet_q  <= s_axis_tdata[31:0];
			rlen_q  <= s_axis_tdata[37:32];
			rport_q <= s_axis_tdata[45:38];
			dest_q  <= s_axis_tdata[77:46];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= lpm_pkg::STAT_OK;
		end else if ((state_q == lpm_pkg::ST_EXEC) && (func_q == lpm_pkg::FUNC_ADD)) begin
			if (rlen_q > lpm_pkg::MAX_LEN) begin
				status_q <= lpm_pkg::STAT_BAD_LEN;
			end else if (count_q >= DEPTH_CNT) begin
				status_q <= lpm_pkg::STAT_FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (mem_we) begin
			count_q <= count_q + 1'b1;
		end else if ((state_q == lpm_pkg::ST_EXEC) && (func_q == lpm_pkg::FUNC_CLEAR)) begin
			count_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_rd;
			if (accept) begin
				idx_q <= '0;
			end else if (scan_rd) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign port_sat = (rport_q > PORT_MAX) ? PORT_MAX : rport_q;
	assign wr_data  = {rnet_q, rlen_q, port_sat[PW-1:0]};

	lpm_route_ram #(
		.DEPTH  (TABLE_DEPTH),
		.IDX_W  (IDX_W),
		.DATA_W (DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.re      (scan_rd),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	lpm_match_unit u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.dest       (dest_q),
		.entry_net  (rd_data[DATA_W-1 -: lpm_pkg::ADDR_W]),
		.entry_len  (rd_data[PW +: lpm_pkg::LEN_W]),
		.entry_port (lpm_pkg::PORT_W'(rd_data[PW-1:0])),
		.res        (match_res)
	);

	// result assembly
	always_comb begin
		result      = '0;
		result[1:0] = status_q;
		if (func_q == lpm_pkg::FUNC_LOOKUP) begin
			if (count_q == '0) begin
				result[2] = 1'b1;
			end else begin
				result[2]     = match_res.found;
				result[10:3]  = match_res.port;
				result[16:11] = match_res.len;
				result[48:17] = match_res.net;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lpm_route_ram.sv =====
// lpm_route_ram: route table storage, one write port and one registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps
`default_nettype none

module lpm_route_ram #(
	parameter int DEPTH  = 128,
	parameter int IDX_W  = 7,
	parameter int DATA_W = 46
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [IDX_W-1:0]  wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              re,
	input  wire logic [IDX_W-1:0]  rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lpm_match_unit.sv =====
// lpm_match_unit: shared prefix compare and best route accumulator, one entry per cycle
// depends on lpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpm_match_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lpm_pkg::scan_ctl_t        ctl,
	input  wire logic [lpm_pkg::ADDR_W-1:0] dest,
	input  wire logic [lpm_pkg::ADDR_W-1:0] entry_net,
	input  wire logic [lpm_pkg::LEN_W-1:0]  entry_len,
	input  wire logic [lpm_pkg::PORT_W-1:0] entry_port,
	output lpm_pkg::match_res_t             res
);

	logic                       found_q;
	logic [lpm_pkg::PORT_W-1:0] port_q;
	logic [lpm_pkg::LEN_W-1:0]  len_q;
	logic [lpm_pkg::ADDR_W-1:0] net_q;
	logic [lpm_pkg::ADDR_W-1:0] mask;
	logic                       hit;
	logic                       take;

	always_comb begin
		mask = lpm_pkg::prefix_mask(entry_len);
		hit  = ((dest ^ entry_net) & mask) == '0;
		take = ctl.entry_vld && hit && (!found_q || (entry_len > len_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			port_q <= '0;
			len_q  <= '0;
			net_q  <= '0;
		end else if (take) begin
			port_q <= entry_port;
			len_q  <= entry_len;
			net_q  <= entry_net;
		end
	end

	assign res.found = found_q;
	assign res.port  = port_q;
	assign res.len   = len_q;
	assign res.net   = net_q;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for longest_prefix_match_lookup_unit
// streams add, lookup and clear commands, predicts each result and checks every beat
// depends on lpm_pkg and the rtl of the lookup unit
`timescale 1ns / 1ps

module tb_top;

	localparam int TABLE_DEPTH    = 128;
	localparam int PHASE_ITEMS    = 330;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		lpm_pkg::func_t             func;
		logic [lpm_pkg::ADDR_W-1:0] net;
		logic [lpm_pkg::LEN_W-1:0]  len;
		logic [lpm_pkg::PORT_W-1:0] port;
		logic [lpm_pkg::ADDR_W-1:0] dest;
	} route_cmd_t;

	typedef struct packed {
		lpm_pkg::status_t           status;
		logic                       matched;
		logic [lpm_pkg::PORT_W-1:0] port;
		logic [lpm_pkg::LEN_W-1:0]  len;
		logic [lpm_pkg::ADDR_W-1:0] net;
	} route_res_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_valid = 1'b0;
	logic                            s_ready;
	logic [lpm_pkg::IN_TDATA_W-1:0]  s_data = '0;
	logic [lpm_pkg::FUNC_W-1:0]      s_user = '0;
	logic                            m_valid;
	logic                            m_rdy = 1'b0;
	logic [lpm_pkg::OUT_TDATA_W-1:0] m_data;

	// predictor state
	logic [lpm_pkg::ADDR_W-1:0] route_net [TABLE_DEPTH];
	logic [lpm_pkg::LEN_W-1:0]  route_len [TABLE_DEPTH];
	logic [lpm_pkg::PORT_W-1:0] route_port [TABLE_DEPTH];
	int                         route_cnt = 0;

	// generator view of the table, used to aim lookups at stored routes
	logic [lpm_pkg::ADDR_W-1:0] gen_net [TABLE_DEPTH];
	logic [lpm_pkg::LEN_W-1:0]  gen_len [TABLE_DEPTH];
	int                         gen_cnt = 0;

	route_cmd_t cmd_fifo [$];
	route_res_t expected_results [$];
	route_cmd_t bus_cmd;

	int   src_idle_pct  = 0;
	int   snk_stall_pct = 0;
	logic hold_req      = 1'b0;
	int   fail_cnt      = 0;
	int   idle_cycles   = 0;

	longest_prefix_match_lookup_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.PORT_BITS  (lpm_pkg::PORT_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata (s_data),
		.s_axis_tuser (s_user),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_rdy),
		.m_axis_tdata (m_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [lpm_pkg::ADDR_W-1:0] route_mask(logic [lpm_pkg::LEN_W-1:0] len);
		route_mask = {lpm_pkg::ADDR_W{1'b1}} << (lpm_pkg::ADDR_W - int'(len));
	endfunction

	function automatic route_res_t predict_route(route_cmd_t c);
		route_res_t                 r;
		logic [lpm_pkg::ADDR_W-1:0] m;
		logic                       found;
		r = '0;
		found = 1'b0;
		case (c.func)
			lpm_pkg::FUNC_ADD: begin
				if (c.len > lpm_pkg::MAX_LEN)
					r.status = lpm_pkg::STAT_BAD_LEN;
				else if (route_cnt >= TABLE_DEPTH)
					r.status = lpm_pkg::STAT_FULL;
				else begin
					route_net[route_cnt] = c.net;
					route_len[route_cnt] = c.len;
					route_port[route_cnt] = c.port;
					route_cnt++;
				end
			end
			lpm_pkg::FUNC_LOOKUP: begin
				if (route_cnt == 0)
					r.matched = 1'b1;
				else begin
					for (int i = 0; i < route_cnt; i++) begin
						m = route_mask(route_len[i]);
						if ((c.dest & m) == (route_net[i] & m)
								&& (!found || route_len[i] > r.len)) begin
							found = 1'b1;
							r.len = route_len[i];
							r.port = route_port[i];
							r.net = route_net[i];
						end
					end
					r.matched = found;
				end
			end
			lpm_pkg::FUNC_CLEAR: route_cnt = 0;
			default: ;
		endcase
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : sender
		if (!arst_n) begin
			s_valid <= 1'b0;
			s_data <= '0;
			s_user <= '0;
		end else begin
			if (s_valid && s_ready)
				expected_results.push_back(predict_route(bus_cmd));
			if (!s_valid || s_ready) begin
				if (cmd_fifo.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					bus_cmd = cmd_fifo.pop_front();
					s_valid <= 1'b1;
					s_data <= {2'b00, bus_cmd.dest, bus_cmd.port, bus_cmd.len, bus_cmd.net};
					s_user <= bus_cmd.func;
				end else begin
					s_valid <= 1'b0;
				end
			end
		end
	end

	task automatic log_mismatch(string what, route_res_t want, route_res_t got);
		fail_cnt++;
		if (fail_cnt <= REPORT_MAX)
			$display({"%0t mismatch (%s): exp st=%0d m=%0d port=%0d len=%0d net=%h,",
				" got st=%0d m=%0d port=%0d len=%0d net=%h"},
				$realtime, what, want.status, want.matched, want.port, want.len, want.net,
				got.status, got.matched, got.port, got.len, got.net);
	endtask

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : receiver
		route_res_t got;
		route_res_t want;
		int         hold_left;
		logic       hold_done;
		if (!arst_n) begin
			m_rdy <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (m_valid && m_rdy) begin
				got.status = lpm_pkg::status_t'(m_data[1:0]);
				got.matched = m_data[2];
				got.port = m_data[10:3];
				got.len = m_data[16:11];
				got.net = m_data[48:17];
				if (expected_results.size() == 0)
					log_mismatch("unexpected beat", '0, got);
				else begin
					want = expected_results.pop_front();
					if (got !== want)
						log_mismatch("field", want, got);
				end
			end
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_rdy <= 1'b0;
			end else begin
				m_rdy <= $urandom_range(99) >= snk_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_valid && s_ready) || (m_valid && m_rdy))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic push_cmd(route_cmd_t c);
		if (c.func == lpm_pkg::FUNC_ADD && c.len <= lpm_pkg::MAX_LEN
				&& gen_cnt < TABLE_DEPTH) begin
			gen_net[gen_cnt] = c.net;
			gen_len[gen_cnt] = c.len;
			gen_cnt++;
		end else if (c.func == lpm_pkg::FUNC_CLEAR)
			gen_cnt = 0;
		cmd_fifo.push_back(c);
	endtask

	function automatic route_cmd_t noise_cmd(lpm_pkg::func_t f);
		route_cmd_t c;
		c.func = f;
		c.net = $urandom;
		c.len = lpm_pkg::LEN_W'($urandom_range(63));
		c.port = lpm_pkg::PORT_W'($urandom);
		c.dest = $urandom;
		return c;
	endfunction

	task automatic push_directed(lpm_pkg::func_t f, logic [31:0] net, logic [5:0] len,
			logic [7:0] port, logic [31:0] dest);
		route_cmd_t c;
		c = '{func: f, net: net, len: len, port: port, dest: dest};
		push_cmd(c);
	endtask

	function automatic logic [lpm_pkg::LEN_W-1:0] pick_len();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return lpm_pkg::LEN_W'($urandom_range(63, 33));
		else if (roll < 12)
			return '0;
		else if (roll < 22)
			return lpm_pkg::MAX_LEN;
		return lpm_pkg::LEN_W'($urandom_range(31, 1));
	endfunction

	task automatic push_add();
		route_cmd_t c;
		int         k;
		c = noise_cmd(lpm_pkg::FUNC_ADD);
		if (gen_cnt > 0 && $urandom_range(99) < 15) begin
			// same prefix as a stored route, the earlier one must win
			k = $urandom_range(gen_cnt - 1);
			c.net = gen_net[k] | ($urandom & ~route_mask(gen_len[k]));
			c.len = gen_len[k];
		end else
			c.len = pick_len();
		push_cmd(c);
	endtask

	task automatic push_lookup();
		route_cmd_t                 c;
		int                         k;
		logic [lpm_pkg::ADDR_W-1:0] m;
		c = noise_cmd(lpm_pkg::FUNC_LOOKUP);
		if (gen_cnt > 0 && $urandom_range(99) < 75) begin
			k = $urandom_range(gen_cnt - 1);
			m = route_mask(gen_len[k]);
			c.dest = (gen_net[k] & m) | ($urandom & ~m);
		end
		push_cmd(c);
	endtask

	task automatic gen_traffic(int n);
		int   issued;
		int   roll;
		logic filled;
		route_cmd_t c;
		issued = 0;
		filled = 1'b0;
		while (issued < n) begin
			if (!filled && issued >= n / 2) begin
				// fill the table, then hit it while full
				filled = 1'b1;
				while (gen_cnt < TABLE_DEPTH) begin
					c = noise_cmd(lpm_pkg::FUNC_ADD);
					c.len = lpm_pkg::LEN_W'($urandom_range(32));
					push_cmd(c);
					issued++;
				end
				push_add();
				c = noise_cmd(lpm_pkg::FUNC_ADD);
				c.len = lpm_pkg::LEN_W'($urandom_range(63, 33));
				push_cmd(c);
				for (int i = 0; i < 4; i++)
					push_lookup();
				push_cmd(noise_cmd(lpm_pkg::FUNC_CLEAR));
				issued += 7;
			end
			roll = $urandom_range(99);
			if (roll < 8) begin
				push_cmd(noise_cmd(lpm_pkg::FUNC_CLEAR));
				issued++;
			end else if (roll < 18) begin
				push_cmd(noise_cmd(lpm_pkg::func_t'($urandom_range(2))));
				issued++;
			end else begin
				for (int i = $urandom_range(6, 1); i > 0; i--) begin
					push_add();
					issued++;
				end
				for (int i = $urandom_range(6, 1); i > 0; i--) begin
					push_lookup();
					issued++;
				end
			end
		end
	endtask

	task automatic drain();
		while (cmd_fifo.size() != 0 || s_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty table answers as default route
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'hFFFF_FFFF);
		// bad length, also on an empty table
		push_directed(lpm_pkg::FUNC_ADD, 32'h0A00_0000, 6'd33, 8'd9, 32'h0);
		push_directed(lpm_pkg::FUNC_ADD, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'hFFFF_FFFF);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h1234_5678);
		push_directed(lpm_pkg::FUNC_ADD, 32'h0A00_0000, 6'd8, 8'd1, 32'h0);
		// host bits kept as stored
		push_directed(lpm_pkg::FUNC_ADD, 32'h0A01_02FF, 6'd24, 8'd2, 32'h0);
		push_directed(lpm_pkg::FUNC_ADD, 32'h0A01_0203, 6'd32, 8'd3, 32'h0);
		// tie with the /24 above
		push_directed(lpm_pkg::FUNC_ADD, 32'h0A01_0200, 6'd24, 8'd4, 32'h0);
		push_directed(lpm_pkg::FUNC_ADD, 32'hFFFF_FFFF, 6'd0, 8'hFF, 32'h0);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h0A01_0203);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h0A01_02AA);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h0A7F_0000);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'hC0A8_0001);
		push_directed(lpm_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'hFFFF_FFFF);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h0A01_0203);
		push_directed(lpm_pkg::FUNC_ADD, 32'h8000_0000, 6'd1, 8'd7, 32'h0);
		// no route matches
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h7FFF_FFFF);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h8000_0000);
		push_directed(lpm_pkg::FUNC_ADD, 32'h0, 6'd32, 8'h80, 32'h0);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h0);
		push_directed(lpm_pkg::FUNC_LOOKUP, 32'h0, 6'd0, 8'd0, 32'h0000_0001);
		push_directed(lpm_pkg::FUNC_CLEAR, 32'h0, 6'd0, 8'd0, 32'h0);

		// long receiver hold while the sender keeps offering
		hold_req = 1'b1;
		for (int p = 0; p < 4; p++) begin
			src_idle_pct = (p == 1) ? 47 : (p == 3) ? 14 : 0;
			snk_stall_pct = (p == 2) ? 47 : (p == 3) ? 14 : 0;
			gen_traffic(PHASE_ITEMS);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== longest_prefix_match_lookup_unit.f =====
hw/rtl/lpm_pkg.sv
hw/rtl/lpm_route_ram.sv
hw/rtl/lpm_match_unit.sv
hw/rtl/longest_prefix_match_lookup_unit.sv
dv/tb_top.sv
